// ===== rtl/least_squares_line_fit_core_macros.svh =====
// Assertion macros for the least-squares line fit core.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef LEAST_SQUARES_LINE_FIT_CORE_MACROS_SVH
`define LEAST_SQUARES_LINE_FIT_CORE_MACROS_SVH

// same-cycle implication
`define LSLF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lslf: same-cycle check failed");

// next-cycle implication
`define LSLF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lslf: next-cycle check failed");

`endif

// ===== rtl/lslf_pkg.sv =====
// Shared types and constants for the least-squares line fit core.
// No dependencies.
`default_nettype none

package lslf_pkg;

  typedef struct packed {
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic               last;
  } lslf_in_t;

  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic [1:0]         status;
  } lslf_out_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_DEGEN    = 2'd1,
    STAT_TOO_MANY = 2'd2,
    STAT_SAT      = 2'd3
  } status_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [1:0] {
    ACC_IDLE,
    ACC_XY,
    ACC_XX,
    ACC_FIN
  } acc_state_e;

  typedef enum logic [2:0] {
    SLV_IDLE,
    SLV_MUL,
    SLV_PSTORE,
    SLV_DABS,
    SLV_NABS,
    SLV_DIV,
    SLV_DSTORE,
    SLV_DONE
  } slv_state_e;

  // closing products, in the order they are formed
  typedef enum logic [2:0] {
    PR_N_SXX,
    PR_SX_SX,
    PR_N_SXY,
    PR_SX_SY,
    PR_SY_SXX,
    PR_SX_SXY
  } prod_e;

  typedef struct packed {
    logic busy;
    logic close;
    logic overflow;
  } lslf_acc_stat_t;

  typedef struct packed {
    logic busy;
    logic clear;
    logic done;
  } lslf_slv_ctl_t;

  localparam int unsigned SLOPE_SHIFT = 16;
  localparam int unsigned INTCP_SHIFT = 8;

endpackage

`default_nettype wire

// ===== rtl/lslf_addsub.sv =====
// Shared add/subtract unit used by the closing sequencer.
// Depends on lslf_pkg.
`default_nettype none

module lslf_addsub import lslf_pkg::*; #(
  parameter int unsigned W = 8
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  alu_op_e      op_i,
  output logic [W-1:0] y_o
);

  always_comb begin
    case (op_i)
      ALU_SUB: y_o = a_i - b_i;
      default: y_o = a_i + b_i;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/lslf_accum.sv =====
// Point accumulator: count and running sums of x, y, x*y and x*x.
// One 16x16 multiplier shared between x*y and x*x. Depends on lslf_pkg.
`default_nettype none

module lslf_accum import lslf_pkg::*; #(
  parameter int unsigned MAX_POINTS = 32
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     accept_i,
  input  lslf_in_t                                 point_i,
  input  logic                                     clear_i,
  output lslf_acc_stat_t                           stat_o,
  output logic [$clog2(MAX_POINTS+1)-1:0]          count_o,
  output logic signed [16+$clog2(MAX_POINTS)-1:0]  sum_x_o,
  output logic signed [16+$clog2(MAX_POINTS)-1:0]  sum_y_o,
  output logic signed [32+$clog2(MAX_POINTS)-1:0]  sum_xy_o,
  output logic signed [32+$clog2(MAX_POINTS)-1:0]  sum_xx_o
);

  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned SXW = 16 + $clog2(MAX_POINTS);
  localparam int unsigned SPW = 32 + $clog2(MAX_POINTS);

  acc_state_e state_q, state_d;

  logic [CW-1:0]         count_q;
  logic signed [SXW-1:0] sum_x_q, sum_y_q;
  logic signed [SPW-1:0] sum_xy_q, sum_xx_q;
  logic                  ovf_q;
  logic                  last_q;
  logic                  take_q;
  logic signed [15:0]    x_q, y_q;
  logic signed [31:0]    prod_q, prod_d;

  logic               ld_point;
  logic               take;
  logic               prod_en;
  logic               xy_en;
  logic               xx_en;
  logic signed [15:0] mul_b;

  assign ld_point = accept_i && (state_q == ACC_IDLE);
  assign take     = count_q < CW'(MAX_POINTS);
  assign prod_d   = x_q * mul_b;

  // x*x first, so sum_xx is settled by the time a fit can start
  always_comb begin
    state_d = state_q;
    case (state_q)
      ACC_IDLE: if (ld_point) state_d = ACC_XX;
      ACC_XX:   state_d = ACC_XY;
      ACC_XY:   state_d = ACC_FIN;
      ACC_FIN:  state_d = ACC_IDLE;
      default:  state_d = ACC_IDLE;
    endcase
  end

  always_comb begin
    mul_b   = x_q;
    prod_en = 1'b0;
    xy_en   = 1'b0;
    xx_en   = 1'b0;
    case (state_q)
      ACC_XX: prod_en = 1'b1;
      ACC_XY: begin
        mul_b   = y_q;
        prod_en = 1'b1;
        xx_en   = take_q;
      end
      ACC_FIN: xy_en = take_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ACC_IDLE;
      count_q  <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xy_q <= '0;
      sum_xx_q <= '0;
      ovf_q    <= 1'b0;
      last_q   <= 1'b0;
      take_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clear_i) begin
        count_q  <= '0;
        sum_x_q  <= '0;
        sum_y_q  <= '0;
        sum_xy_q <= '0;
        sum_xx_q <= '0;
        ovf_q    <= 1'b0;
      end else begin
        if (ld_point) begin
          last_q <= point_i.last;
          take_q <= take;
          if (take) begin
            count_q <= count_q + CW'(1);
            sum_x_q <= sum_x_q + SXW'(point_i.x_value);
            sum_y_q <= sum_y_q + SXW'(point_i.y_value);
          end else begin
            ovf_q <= 1'b1;
          end
        end
        if (xy_en) sum_xy_q <= sum_xy_q + SPW'(prod_q);
        if (xx_en) sum_xx_q <= sum_xx_q + SPW'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_point) begin
      x_q <= point_i.x_value;
      y_q <= point_i.y_value;
    end
    if (prod_en) prod_q <= prod_d;
  end

  assign stat_o.busy     = (state_q != ACC_IDLE);
  assign stat_o.close    = (state_q == ACC_FIN) && last_q;
  assign stat_o.overflow = ovf_q;

  assign count_o  = count_q;
  assign sum_x_o  = sum_x_q;
  assign sum_y_o  = sum_y_q;
  assign sum_xy_o = sum_xy_q;
  assign sum_xx_o = sum_xx_q;

endmodule

`default_nettype wire

// ===== rtl/lslf_solver.sv =====
// Closing sequencer: six shift-add products, three differences and two
// restoring divisions, all on one shared adder. Depends on lslf_pkg, lslf_addsub.
`default_nettype none

module lslf_solver import lslf_pkg::*; #(
  parameter int unsigned MAX_POINTS = 32
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  lslf_acc_stat_t                           acc_i,
  input  logic [$clog2(MAX_POINTS+1)-1:0]          count_i,
  input  logic signed [16+$clog2(MAX_POINTS)-1:0]  sum_x_i,
  input  logic signed [16+$clog2(MAX_POINTS)-1:0]  sum_y_i,
  input  logic signed [32+$clog2(MAX_POINTS)-1:0]  sum_xy_i,
  input  logic signed [32+$clog2(MAX_POINTS)-1:0]  sum_xx_i,
  output lslf_slv_ctl_t                            ctl_o,
  output lslf_out_t                                result_o
);

  localparam int unsigned SXW = 16 + $clog2(MAX_POINTS);
  localparam int unsigned SPW = 32 + $clog2(MAX_POINTS);
  localparam int unsigned AW  = SXW + SPW + 1;
  localparam int unsigned UW  = AW + 1;
  localparam int unsigned MCW = $clog2(SXW);
  localparam int unsigned DCW = $clog2(AW + SLOPE_SHIFT);

  slv_state_e state_q, state_d;

  prod_e               pidx_q, pidx_d;
  logic [MCW-1:0]      mcnt_q, mcnt_d;
  logic [DCW-1:0]      dcnt_q, dcnt_d;
  logic                div_sel_q, div_sel_d;
  logic [AW-1:0]       acc_q, acc_d;
  logic [AW-1:0]       mc_q, mc_d;
  logic [SXW-1:0]      mp_q, mp_d;
  logic [AW-1:0]       ta_q, ta_d;
  logic [AW-1:0]       den_q, den_d;
  logic [AW-1:0]       snum_q, snum_d;
  logic [AW-1:0]       inum_q, inum_d;
  logic [AW-1:0]       dmag_q, dmag_d;
  logic [AW-1:0]       nmag_q, nmag_d;
  logic [AW-1:0]       rem_q, rem_d;
  logic [32:0]         q_q, q_d;
  logic                big_q, big_d;
  logic                neg_q, neg_d;
  logic                sat_q, sat_d;
  logic [31:0]         slope_q, slope_d;
  logic [31:0]         icpt_q, icpt_d;
  status_e             status_q, status_d;

  logic [UW-1:0]       unit_a, unit_b, unit_y;
  alu_op_e             unit_op;
  logic [AW-1:0]       res;
  logic [UW-1:0]       trial;
  logic [AW-1:0]       num_sel;
  logic                den_neg;
  logic                mul_last;
  logic [DCW-1:0]      div_last;
  logic                start_fit;
  logic                load_mul;
  prod_e               sel_idx;
  logic [AW-1:0]       sel_a;
  logic signed [SXW-1:0] sel_b;
  logic                sat_now;
  logic [31:0]         qneg;
  logic [31:0]         quot;

  lslf_addsub #(.W(UW)) u_alu (
    .a_i  (unit_a),
    .b_i  (unit_b),
    .op_i (unit_op),
    .y_o  (unit_y)
  );

  assign res       = unit_y[AW-1:0];
  assign trial     = {rem_q, nmag_q[AW-1]};
  assign num_sel   = div_sel_q ? inum_q : snum_q;
  assign den_neg   = den_q[AW-1];
  assign mul_last  = (mcnt_q == MCW'(SXW - 1));
  assign div_last  = div_sel_q ? DCW'(AW + INTCP_SHIFT - 1) : DCW'(AW + SLOPE_SHIFT - 1);
  assign start_fit = (state_q == SLV_IDLE) && acc_i.close && !acc_i.overflow;
  assign load_mul  = start_fit ||
                     ((state_q == SLV_PSTORE) && (state_d == SLV_MUL));
  assign sel_idx   = (state_q == SLV_IDLE) ? PR_N_SXX : prod_e'(pidx_q + 3'd1);

  // operands of the next product; the multiplier is taken as two's complement
  always_comb begin
    sel_a = '0;
    sel_b = '0;
    case (sel_idx)
      PR_N_SXX: begin
        sel_a = AW'(sum_xx_i);
        sel_b = SXW'(count_i);
      end
      PR_SX_SX: begin
        sel_a = AW'(sum_x_i);
        sel_b = sum_x_i;
      end
      PR_N_SXY: begin
        sel_a = AW'(sum_xy_i);
        sel_b = SXW'(count_i);
      end
      PR_SX_SY: begin
        sel_a = AW'(sum_y_i);
        sel_b = sum_x_i;
      end
      PR_SY_SXX: begin
        sel_a = AW'(sum_xx_i);
        sel_b = sum_y_i;
      end
      PR_SX_SXY: begin
        sel_a = AW'(sum_xy_i);
        sel_b = sum_x_i;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SLV_IDLE: begin
        if (acc_i.close) state_d = acc_i.overflow ? SLV_DONE : SLV_MUL;
      end
      SLV_MUL: if (mul_last) state_d = SLV_PSTORE;
      SLV_PSTORE: begin
        if ((pidx_q == PR_SX_SX) && (res == '0)) state_d = SLV_DONE;
        else if (pidx_q == PR_SX_SXY)            state_d = SLV_DABS;
        else                                     state_d = SLV_MUL;
      end
      SLV_DABS:   state_d = SLV_NABS;
      SLV_NABS:   state_d = SLV_DIV;
      SLV_DIV:    if (dcnt_q == div_last) state_d = SLV_DSTORE;
      SLV_DSTORE: state_d = div_sel_q ? SLV_DONE : SLV_NABS;
      SLV_DONE:   state_d = SLV_IDLE;
      default:    state_d = SLV_IDLE;
    endcase
  end

  // shared unit operand selection
  always_comb begin
    unit_a  = '0;
    unit_b  = '0;
    unit_op = ALU_ADD;
    case (state_q)
      SLV_MUL: begin
        unit_a  = {1'b0, acc_q};
        unit_b  = {1'b0, mc_q};
        // sign bit of the multiplier carries negative weight
        unit_op = mul_last ? ALU_SUB : ALU_ADD;
      end
      SLV_PSTORE: begin
        unit_a  = {1'b0, ta_q};
        unit_b  = {1'b0, acc_q};
        unit_op = ALU_SUB;
      end
      SLV_DABS: begin
        unit_a  = den_neg ? '0 : {1'b0, den_q};
        unit_b  = den_neg ? {1'b0, den_q} : '0;
        unit_op = den_neg ? ALU_SUB : ALU_ADD;
      end
      SLV_NABS: begin
        unit_a  = num_sel[AW-1] ? '0 : {1'b0, num_sel};
        unit_b  = num_sel[AW-1] ? {1'b0, num_sel} : '0;
        unit_op = num_sel[AW-1] ? ALU_SUB : ALU_ADD;
      end
      SLV_DIV: begin
        unit_a  = trial;
        unit_b  = {1'b0, dmag_q};
        unit_op = ALU_SUB;
      end
      default: ;
    endcase
  end

  assign qneg    = ~q_q[31:0] + 32'd1;
  assign sat_now = big_q || (neg_q ? (q_q > 33'h080000000) : (q_q > 33'h07FFFFFFF));
  assign quot    = sat_now ? (neg_q ? 32'h80000000 : 32'h7FFFFFFF)
                           : (neg_q ? qneg : q_q[31:0]);

  // datapath
  always_comb begin
    pidx_d    = pidx_q;
    mcnt_d    = mcnt_q;
    dcnt_d    = dcnt_q;
    div_sel_d = div_sel_q;
    acc_d     = acc_q;
    mc_d      = mc_q;
    mp_d      = mp_q;
    ta_d      = ta_q;
    den_d     = den_q;
    snum_d    = snum_q;
    inum_d    = inum_q;
    dmag_d    = dmag_q;
    nmag_d    = nmag_q;
    rem_d     = rem_q;
    q_d       = q_q;
    big_d     = big_q;
    neg_d     = neg_q;
    sat_d     = sat_q;
    slope_d   = slope_q;
    icpt_d    = icpt_q;
    status_d  = status_q;

    if ((state_q == SLV_IDLE) && acc_i.close) begin
      status_d  = acc_i.overflow ? STAT_TOO_MANY : STAT_OK;
      slope_d   = '0;
      icpt_d    = '0;
      sat_d     = 1'b0;
      div_sel_d = 1'b0;
    end

    case (state_q)
      SLV_MUL: begin
        if (mp_q[0]) acc_d = res;
        mc_d   = mc_q << 1;
        mp_d   = mp_q >> 1;
        mcnt_d = mcnt_q + MCW'(1);
      end
      SLV_PSTORE: begin
        case (pidx_q)
          PR_SX_SX: begin
            den_d = res;
            if (res == '0) status_d = STAT_DEGEN;
          end
          PR_SX_SY:  snum_d = res;
          PR_SX_SXY: inum_d = res;
          default:   ta_d   = acc_q;
        endcase
      end
      SLV_DABS: dmag_d = res;
      SLV_NABS: begin
        nmag_d = res;
        neg_d  = num_sel[AW-1] ^ den_neg;
        rem_d  = '0;
        q_d    = '0;
        big_d  = 1'b0;
        dcnt_d = '0;
      end
      SLV_DIV: begin
        // restoring step; a non-negative difference sets the quotient bit
        rem_d  = unit_y[UW-1] ? trial[AW-1:0] : res;
        nmag_d = nmag_q << 1;
        q_d    = {q_q[31:0], ~unit_y[UW-1]};
        if (q_q[32]) big_d = 1'b1;
        dcnt_d = dcnt_q + DCW'(1);
      end
      SLV_DSTORE: begin
        if (div_sel_q) begin
          icpt_d   = quot;
          status_d = (sat_q || sat_now) ? STAT_SAT : STAT_OK;
        end else begin
          slope_d  = quot;
        end
        sat_d     = sat_q || sat_now;
        div_sel_d = 1'b1;
      end
      default: ;
    endcase

    if (load_mul) begin
      pidx_d = sel_idx;
      acc_d  = '0;
      mc_d   = sel_a;
      mp_d   = sel_b;
      mcnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SLV_IDLE;
      pidx_q    <= PR_N_SXX;
      mcnt_q    <= '0;
      dcnt_q    <= '0;
      div_sel_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pidx_q    <= pidx_d;
      mcnt_q    <= mcnt_d;
      dcnt_q    <= dcnt_d;
      div_sel_q <= div_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mc_q     <= mc_d;
    mp_q     <= mp_d;
    ta_q     <= ta_d;
    den_q    <= den_d;
    snum_q   <= snum_d;
    inum_q   <= inum_d;
    dmag_q   <= dmag_d;
    nmag_q   <= nmag_d;
    rem_q    <= rem_d;
    q_q      <= q_d;
    big_q    <= big_d;
    neg_q    <= neg_d;
    sat_q    <= sat_d;
    slope_q  <= slope_d;
    icpt_q   <= icpt_d;
    status_q <= status_d;
  end

  assign ctl_o.busy  = (state_q != SLV_IDLE);
  assign ctl_o.clear = (state_q == SLV_DONE);
  assign ctl_o.done  = (state_q == SLV_DONE);

  assign result_o.slope     = slope_q;
  assign result_o.intercept = icpt_q;
  assign result_o.status    = status_q;

endmodule

`default_nettype wire

// ===== rtl/least_squares_line_fit_core.sv =====
// Least-squares line fit core, top level.
// Depends on lslf_pkg, lslf_accum, lslf_solver and the assertion macro header.
//
//   channel   signals                      accepted when
//   point     start, point_i, busy         start && !busy at a rising edge
//   result    result_valid_o, result_o     every cycle result_valid_o is high
//
// A point keeps busy high while the accumulator steps through ACC_XX, ACC_XY
// and ACC_FIN (the shared 16x16 multiplier forms x*x, then x*y), so a new
// point is taken only once the last is through. After a point marked last
// the closing pass runs on the shared adder, widths SXW = 16+clog2(MAX_POINTS)
// and AW = 2*SXW+17; a zero denominator ends it early. The strobe lasts one
// cycle and cannot be stalled; reset clears control state and sums only.
`default_nettype none

`include "least_squares_line_fit_core_macros.svh"

module least_squares_line_fit_core import lslf_pkg::*; #(
  parameter int unsigned MAX_POINTS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  lslf_in_t  point_i,
  output logic      busy,
  output logic      result_valid_o,
  output lslf_out_t result_o
);

  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned SXW = 16 + $clog2(MAX_POINTS);
  localparam int unsigned SPW = 32 + $clog2(MAX_POINTS);

  lslf_acc_stat_t        acc_stat;
  lslf_slv_ctl_t         slv_ctl;
  logic                  accept;
  logic                  fit_failed;
  logic [CW-1:0]         count;
  logic signed [SXW-1:0] sum_x, sum_y;
  logic signed [SPW-1:0] sum_xy, sum_xx;

  assign busy   = acc_stat.busy || slv_ctl.busy;
  assign accept = start && !busy;

  lslf_accum #(.MAX_POINTS(MAX_POINTS)) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .point_i  (point_i),
    .clear_i  (slv_ctl.clear),
    .stat_o   (acc_stat),
    .count_o  (count),
    .sum_x_o  (sum_x),
    .sum_y_o  (sum_y),
    .sum_xy_o (sum_xy),
    .sum_xx_o (sum_xx)
  );

  lslf_solver #(.MAX_POINTS(MAX_POINTS)) u_solver (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc_stat),
    .count_i  (count),
    .sum_x_i  (sum_x),
    .sum_y_i  (sum_y),
    .sum_xy_i (sum_xy),
    .sum_xx_i (sum_xx),
    .ctl_o    (slv_ctl),
    .result_o (result_o)
  );

  assign result_valid_o = slv_ctl.done;

  assign fit_failed = result_valid_o &&
                      (result_o.status inside {STAT_DEGEN, STAT_TOO_MANY});

  `LSLF_ASSERT_IMP(a_strobe_while_busy, result_valid_o, busy)
  `LSLF_ASSERT_NXT(a_strobe_one_cycle, result_valid_o, !result_valid_o)
  `LSLF_ASSERT_NXT(a_accept_sets_busy, start && !busy, busy)
  `LSLF_ASSERT_IMP(a_failed_fit_zero, fit_failed, (result_o.slope == '0) && (result_o.intercept == '0))

endmodule

`default_nettype wire

// ===== test/least_squares_line_fit_core_checker.sv =====
// Checker for the least-squares line fit core: watches the point and result
// channels, predicts each fit and compares it field by field.
// Depends on lslf_pkg.
module least_squares_line_fit_core_checker import lslf_pkg::*; #(
  parameter int unsigned MAX_POINTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  lslf_in_t    point_i,
  input  logic        result_valid_i,
  input  lslf_out_t   result_i,
  output int unsigned fits_pending_o,
  output int unsigned error_count_o
);

  localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
  localparam logic signed [127:0] Q_MIN = -128'sd2147483648;

  int unsigned pt_count;
  longint      acc_x;
  longint      acc_y;
  longint      acc_xy;
  longint      acc_xx;
  bit          pts_overflow;
  lslf_out_t   expected_fits[$];
  lslf_out_t   want;

  function automatic logic signed [31:0] clamp_q1616(input logic signed [127:0] q,
                                                     output bit sat);
    logic signed [31:0] v;
    sat = 1'b1;
    if (q > Q_MAX) begin
      v = 32'sh7FFF_FFFF;
    end else if (q < Q_MIN) begin
      v = 32'sh8000_0000;
    end else begin
      v = q[31:0];
      sat = 1'b0;
    end
    return v;
  endfunction

  // exact fit from the integer sums; SV signed division truncates toward zero
  function automatic lslf_out_t fit_line(input int unsigned n, input longint sx, sy,
                                         input longint sxy, sxx, input bit ovf);
    logic signed [127:0] wn, wsx, wsy, wsxy, wsxx, den;
    bit        sat_s, sat_i;
    lslf_out_t fit;
    fit = '0;
    fit.status = STAT_OK;
    if (ovf) begin
      fit.status = STAT_TOO_MANY;
    end else begin
      wn   = n;
      wsx  = sx;
      wsy  = sy;
      wsxy = sxy;
      wsxx = sxx;
      den  = wn * wsxx - wsx * wsx;
      if (den == 0) begin
        fit.status = STAT_DEGEN;
      end else begin
        fit.slope     = clamp_q1616(((wn * wsxy - wsx * wsy) <<< SLOPE_SHIFT) / den, sat_s);
        fit.intercept = clamp_q1616(((wsy * wsxx - wsx * wsxy) <<< INTCP_SHIFT) / den, sat_i);
        if (sat_s || sat_i) fit.status = STAT_SAT;
      end
    end
    return fit;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want_v, got_v);
    if (want_v !== got_v) begin
      error_count_o++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_count     = 0;
      acc_x        = 0;
      acc_y        = 0;
      acc_xy       = 0;
      acc_xx       = 0;
      pts_overflow = 1'b0;
      expected_fits.delete();
      fits_pending_o <= 0;
    end else begin
      if (result_valid_i) begin
        if (expected_fits.size() == 0) begin
          error_count_o++;
          $display("%0t: unexpected result, expected none, got %h %h %h", $time,
                   result_i.slope, result_i.intercept, result_i.status);
        end else begin
          want = expected_fits.pop_front();
          check_field("slope", want.slope, result_i.slope);
          check_field("intercept", want.intercept, result_i.intercept);
          check_field("status", 32'(want.status), 32'(result_i.status));
        end
      end
      if (start_i && !busy_i) begin
        if (pt_count >= MAX_POINTS) begin
          pts_overflow = 1'b1;
        end else begin
          pt_count++;
          acc_x  += longint'(point_i.x_value);
          acc_y  += longint'(point_i.y_value);
          acc_xy += longint'(point_i.x_value) * longint'(point_i.y_value);
          acc_xx += longint'(point_i.x_value) * longint'(point_i.x_value);
        end
        if (point_i.last) begin
          expected_fits.push_back(fit_line(pt_count, acc_x, acc_y, acc_xy, acc_xx,
                                           pts_overflow));
          pt_count     = 0;
          acc_x        = 0;
          acc_y        = 0;
          acc_xy       = 0;
          acc_xx       = 0;
          pts_overflow = 1'b0;
        end
      end
      fits_pending_o <= expected_fits.size();
    end
  end

endmodule

// ===== test/least_squares_line_fit_core_tb.sv =====
// Testbench top for the least-squares line fit core: drives point sets with
// random gaps and gives the verdict. Depends on lslf_pkg, the core and the checker.
module least_squares_line_fit_core_tb;
  import lslf_pkg::*;

  localparam int unsigned MAX_PTS      = 32;
  localparam int unsigned POINT_TARGET = 1900;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT  = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  lslf_in_t    point_i = '0;
  logic        busy;
  logic        result_valid_o;
  lslf_out_t   result_o;
  int unsigned fits_pending;
  int unsigned error_count;
  int unsigned points_sent = 0;
  int unsigned cycle_count = 0;

  always #6 clk_i = ~clk_i;

  least_squares_line_fit_core #(.MAX_POINTS(MAX_PTS)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .point_i        (point_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  least_squares_line_fit_core_checker #(.MAX_POINTS(MAX_PTS)) fit_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .point_i        (point_i),
    .result_valid_i (result_valid_o),
    .result_i       (result_o),
    .fits_pending_o (fits_pending),
    .error_count_o  (error_count)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic signed [15:0] pick_coord();
    int unsigned roll;
    logic signed [15:0] v;
    roll = $urandom_range(0, 9);
    if (roll < 6) begin
      v = 16'($urandom);
    end else if (roll < 8) begin
      v = 16'($urandom_range(0, 1023)) - 16'sd512;
    end else begin
      case ($urandom_range(0, 5))
        0:       v = -16'sd32768;
        1:       v = -16'sd32767;
        2:       v = -16'sd1;
        3:       v = 16'sd0;
        4:       v = 16'sd1;
        default: v = 16'sd32767;
      endcase
    end
    return v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // holds start high until the item is taken
  task automatic send_point(input logic signed [15:0] x, y, input logic lst,
                            input int unsigned gap);
    lslf_in_t pt;
    if (gap > 0) begin
      start   <= 1'b0;
      point_i <= lslf_in_t'(33'($urandom));
      repeat (gap) @(posedge clk_i);
    end
    pt.x_value = x;
    pt.y_value = y;
    pt.last    = lst;
    start   <= 1'b1;
    point_i <= pt;
    do @(posedge clk_i); while (busy);
    points_sent++;
  endtask

  task automatic wait_fits_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (fits_pending != 0);
  endtask

  initial begin
    int unsigned kind, set_size, sets_done, i;
    bit          burst;
    logic signed [15:0] base_x, x, y;
    sets_done = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone point: degenerate
    send_point(16'sd100, 16'sd50, 1'b1, 0);
    // every x equal, at the extremes
    send_point(-16'sd32768, -16'sd32768, 1'b0, 1);
    send_point(-16'sd32768, 16'sd32767, 1'b1, 0);
    // unit slope through the origin
    send_point(16'sd0, 16'sd0, 1'b0, 0);
    send_point(16'sd256, 16'sd256, 1'b1, 2);
    // one-LSB step in x, full swing in y: slope clamps
    send_point(16'sd0, -16'sd32768, 1'b0, 0);
    send_point(16'sd1, 16'sd32767, 1'b1, 0);
    // steep line far from the origin: intercept clamps alone
    send_point(16'sd32767, 16'sd32767, 1'b0, 0);
    send_point(16'sd32639, -16'sd32768, 1'b1, 0);
    send_point(-16'sd32768, 16'sd32767, 1'b0, 0);
    send_point(16'sd32767, -16'sd32768, 1'b0, 3);
    send_point(16'sd0, 16'sd0, 1'b1, 0);
    send_point(16'sd32767, 16'sd32767, 1'b0, 0);
    send_point(-16'sd32768, -16'sd32768, 1'b0, 0);
    send_point(-16'sd1, 16'sd1, 1'b0, 0);
    send_point(16'sd1, -16'sd1, 1'b1, 0);
    wait_fits_drained();

    while (points_sent < POINT_TARGET) begin
      kind   = $urandom_range(0, 99);
      burst  = ($urandom_range(0, 3) == 0);
      base_x = pick_coord();
      if (kind < 55)      set_size = $urandom_range(2, 8);
      else if (kind < 70) set_size = $urandom_range(9, MAX_PTS);
      else if (kind < 78) set_size = $urandom_range(MAX_PTS, MAX_PTS + 8);
      else if (kind < 86) set_size = $urandom_range(1, 6);
      else if (kind < 94) set_size = $urandom_range(2, 4);
      else                set_size = 1;
      for (i = 0; i < set_size; i++) begin
        if (kind >= 78 && kind < 86)      x = base_x;                    // flat in x
        else if (kind >= 86 && kind < 94) x = base_x + 16'($urandom_range(0, 2));
        else                              x = pick_coord();
        y = pick_coord();
        send_point(x, y, i == set_size - 1, burst ? 0 : pick_gap());
      end
      sets_done++;
      if (sets_done % 25 == 0) wait_fits_drained();
    end

    wait_fits_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
